// ===== rtl/core/text_page_glyph_renderer_macros.svh =====
// Assertion macros for the text page glyph renderer.
// Needs signals named clock, reset and state_ff in the module that uses them.
`ifndef TEXT_PAGE_GLYPH_RENDERER_MACROS_SVH
`define TEXT_PAGE_GLYPH_RENDERER_MACROS_SVH

// Property checked on every rising clock edge, off during reset.
`define TPGR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// State from_st on one edge is followed by state to_st on the next.
`define TPGR_STATE_NEXT(lbl, from_st, to_st, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) \
      (state_ff == from_st) |=> (state_ff == to_st)) else $error(msg);

`endif

// ===== rtl/core/tpgr_pkg.sv =====
// Package for the text page glyph renderer: operation and placement codes,
// character constants and the 5x6 glyph ROM for 'A'..'Z'. No dependencies.
package tpgr_pkg;

   localparam int GLYPH_W = 6;
   localparam int GLYPH_H = 5;
   localparam int COORD_W = 13;

   localparam logic [1:0] OP_WRITE_SMALL = 2'd0;
   localparam logic [1:0] OP_WRITE_LARGE = 2'd1;
   localparam logic [1:0] OP_READ        = 2'd2;

   localparam logic [1:0] PLACE_AT     = 2'd0;
   localparam logic [1:0] PLACE_LEFT   = 2'd1;
   localparam logic [1:0] PLACE_RIGHT  = 2'd2;
   localparam logic [1:0] PLACE_CENTER = 2'd3;

   localparam logic [7:0] CHAR_BLANK = 8'd46;
   localparam logic [7:0] CHAR_INK   = 8'd42;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_A     = 8'd65;
   localparam logic [7:0] CHAR_Z     = 8'd90;

   typedef logic [GLYPH_W-1:0]         glyph_row_type;
   typedef logic [GLYPH_H*GLYPH_W-1:0] glyph_type;
   typedef logic signed [COORD_W-1:0]  coord_type;

   // top glyph row in the upper bits, leftmost pixel is bit 5 of a row
   localparam glyph_type GLYPH_ROM [0:25] = '{
      {6'h1C, 6'h22, 6'h3E, 6'h22, 6'h22}, {6'h3C, 6'h22, 6'h3C, 6'h22, 6'h3C},
      {6'h1E, 6'h22, 6'h20, 6'h20, 6'h1E}, {6'h3C, 6'h22, 6'h22, 6'h22, 6'h3C},
      {6'h3E, 6'h20, 6'h38, 6'h20, 6'h3E}, {6'h3E, 6'h20, 6'h38, 6'h20, 6'h20},
      {6'h1E, 6'h20, 6'h26, 6'h22, 6'h1C}, {6'h22, 6'h22, 6'h3E, 6'h22, 6'h22},
      {6'h3E, 6'h08, 6'h08, 6'h08, 6'h3E}, {6'h0E, 6'h04, 6'h04, 6'h24, 6'h18},
      {6'h22, 6'h24, 6'h38, 6'h24, 6'h22}, {6'h20, 6'h20, 6'h20, 6'h20, 6'h3E},
      {6'h22, 6'h36, 6'h2A, 6'h22, 6'h22}, {6'h22, 6'h32, 6'h2A, 6'h26, 6'h22},
      {6'h1C, 6'h22, 6'h22, 6'h22, 6'h1C}, {6'h3C, 6'h22, 6'h3C, 6'h20, 6'h20},
      {6'h1C, 6'h22, 6'h22, 6'h26, 6'h1E}, {6'h3C, 6'h22, 6'h3C, 6'h24, 6'h22},
      {6'h1E, 6'h20, 6'h1C, 6'h02, 6'h3C}, {6'h3E, 6'h2A, 6'h08, 6'h08, 6'h1C},
      {6'h22, 6'h22, 6'h22, 6'h22, 6'h1C}, {6'h22, 6'h22, 6'h14, 6'h14, 6'h08},
      {6'h22, 6'h22, 6'h2A, 6'h36, 6'h22}, {6'h22, 6'h14, 6'h08, 6'h14, 6'h22},
      {6'h22, 6'h14, 6'h08, 6'h08, 6'h08}, {6'h3E, 6'h04, 6'h08, 6'h10, 6'h3E}
   };

   function automatic glyph_row_type glyph_row(input logic [4:0] letter,
                                               input logic [2:0] y);
      glyph_type     g;
      glyph_row_type r;
      g = '0;
      if (letter < 5'd26) begin
         g = GLYPH_ROM[letter];
      end
      case (y)
         3'd0:    r = g[29:24];
         3'd1:    r = g[23:18];
         3'd2:    r = g[17:12];
         3'd3:    r = g[11:6];
         3'd4:    r = g[5:0];
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/text_page_glyph_renderer.sv =====
// Text page glyph renderer: page memory, placement and draw sequencer.
// Depends on tpgr_pkg and text_page_glyph_renderer_macros.svh.
//
// Usage:
//   req_* channel carries one item: a small-font write, a large-font write or a
//   read-and-clear of one cell. rsp_* channel returns one cell_value per read;
//   writes return nothing. An item is taken when valid is high and stall low.
//   req_stall is high whenever the sequencer is busy; one item is in work at
//   a time.
//   A write goes through the placement and draw states; a large-font letter
//   steps over all 30 glyph pixels and writes those that are ink on the page.
//   A read passes the read and response states, a read off the page only the
//   latter. A space, non-letter large write or unused operation writes nothing.
//   Draw and read addresses go through one shared row*PAGE_SIZE+column unit
//   feeding a single memory port; the clear sweep uses its own counter.
//   Reset: synchronous. After reset the block sweeps all PAGE_SIZE*PAGE_SIZE
//   cells of the page to '.' (3600 at the default), one cell per cycle, with
//   req_stall high.
//   Receiver stall: the result waits in the output register; a read behind it
//   holds in the response state until the register frees up.
`include "text_page_glyph_renderer_macros.svh"

module text_page_glyph_renderer #(
   parameter int PAGE_SIZE = 60
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_operation,
   input  logic [1:0] req_placement,
   input  logic [5:0] req_row,
   input  logic [5:0] req_column,
   input  logic [7:0] req_word_length,
   input  logic [7:0] req_char_index,
   input  logic [7:0] req_character,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_cell_value
);
   import tpgr_pkg::*;

   localparam int DEPTH = PAGE_SIZE * PAGE_SIZE;
   localparam int AW    = $clog2(DEPTH);
   localparam int HALF  = PAGE_SIZE / 2;

   localparam logic [AW-1:0] PAGE_AW  = AW'(PAGE_SIZE);
   localparam logic [AW-1:0] LAST_AW  = AW'(DEPTH - 1);
   localparam logic [8:0]    PAGE_9   = 9'(PAGE_SIZE);
   localparam coord_type     PAGE_C   = COORD_W'(PAGE_SIZE);
   localparam coord_type     HALF_C   = COORD_W'(HALF);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_PLACE = 3'd2;
   localparam logic [2:0] ST_DRAW  = 3'd3;
   localparam logic [2:0] ST_READ  = 3'd4;
   localparam logic [2:0] ST_RESP  = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [2:0]    p_ff, p_in;
   logic [2:0]    y_ff, y_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_value_ff, rsp_value_in;

   logic [1:0]    place_ff;
   logic [5:0]    row_ff, col_ff;
   logic [7:0]    len_ff, idx_ff, char_ff;
   logic          large_ff, rd_blank_ff;
   coord_type     x0_ff, x0_in;

   logic [7:0]    mem [0:DEPTH-1];
   logic [7:0]    mem_rdata_ff;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;

   logic          req_accept, rsp_free;
   logic          req_letter, req_on_page;
   coord_type     len_ext, idx_ext, span, idx_term, start;
   coord_type     draw_x;
   logic [8:0]    draw_y;
   logic          draw_on_page, draw_ink, draw_last;
   glyph_row_type glyph_bits;
   logic [7:0]    unit_row, unit_col;
   logic [AW-1:0] unit_addr;
   logic          we_state_ok, draw_in_glyph;

   assign req_stall      = (state_ff != ST_IDLE);
   assign req_accept     = req_valid && !req_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = rsp_value_ff;
   assign rsp_free       = !rsp_valid_ff || !rsp_stall;

   assign req_letter  = req_character inside {[CHAR_A:CHAR_Z]};
   assign req_on_page = (req_row != 6'd0) && (9'(req_row) <= PAGE_9) &&
                        (req_column != 6'd0) && (9'(req_column) <= PAGE_9);

   // start column of the character, zero-based
   always_comb begin
      len_ext  = coord_type'({{(COORD_W-8){1'b0}}, len_ff});
      idx_ext  = coord_type'({{(COORD_W-8){1'b0}}, idx_ff});
      span     = large_ff ? (len_ext <<< 2) + (len_ext <<< 1) : len_ext;
      idx_term = large_ff ? (idx_ext <<< 2) + (idx_ext <<< 1) : idx_ext;
      case (place_ff)
         PLACE_AT:     start = coord_type'({{(COORD_W-6){1'b0}}, col_ff}) - coord_type'(1);
         PLACE_LEFT:   start = '0;
         PLACE_RIGHT:  start = PAGE_C - span;
         PLACE_CENTER: start = HALF_C - (span >>> 1);
         default:      start = '0;
      endcase
      x0_in = start + idx_term;
   end

   // current pixel
   always_comb begin
      draw_x       = x0_ff + coord_type'({{(COORD_W-3){1'b0}}, p_ff});
      draw_y       = 9'(row_ff) + 9'(y_ff);
      draw_on_page = (draw_y != 9'd0) && (draw_y <= PAGE_9) &&
                     (draw_x >= coord_type'(0)) && (draw_x < PAGE_C);
      glyph_bits   = glyph_row(5'(char_ff - CHAR_A), y_ff);
      draw_ink     = large_ff ? glyph_bits[3'(GLYPH_W - 1) - p_ff] : 1'b1;
      draw_last    = !large_ff ||
                     ((p_ff == 3'(GLYPH_W - 1)) && (y_ff == 3'(GLYPH_H - 1)));
   end

   // shared address unit: row * PAGE_SIZE + column
   always_comb begin
      if (state_ff == ST_READ) begin
         unit_row = 8'(row_ff) - 8'd1;
         unit_col = 8'(col_ff) - 8'd1;
      end else begin
         unit_row = 8'(draw_y - 9'd1);
         unit_col = draw_x[7:0];
      end
      unit_addr = AW'(unit_row) * PAGE_AW + AW'(unit_col);
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = unit_addr;
      mem_wdata = CHAR_BLANK;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
         end
         ST_DRAW: begin
            mem_we    = draw_on_page && draw_ink;
            mem_wdata = large_ff ? CHAR_INK : char_ff;
         end
         ST_READ: begin
            mem_we = 1'b1;
            mem_re = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      p_in         = p_ff;
      y_in         = y_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_AW) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            p_in = '0;
            y_in = '0;
            if (req_accept) begin
               if (req_operation == OP_READ) begin
                  state_in = req_on_page ? ST_READ : ST_RESP;
               end else if (req_character != CHAR_SPACE) begin
                  if (req_operation == OP_WRITE_SMALL ||
                      (req_operation == OP_WRITE_LARGE && req_letter)) begin
                     state_in = ST_PLACE;
                  end
               end
            end
         end
         ST_PLACE: begin
            state_in = ST_DRAW;
         end
         ST_DRAW: begin
            if (draw_last) begin
               state_in = ST_IDLE;
            end else if (p_ff == 3'(GLYPH_W - 1)) begin
               p_in = '0;
               y_in = y_ff + 3'd1;
            end else begin
               p_in = p_ff + 3'd1;
            end
         end
         ST_READ: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = rd_blank_ff ? CHAR_BLANK : mem_rdata_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         p_ff         <= '0;
         y_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         p_ff         <= p_in;
         y_ff         <= y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      if (state_ff == ST_PLACE) begin
         x0_ff <= x0_in;
      end
      if (req_accept) begin
         place_ff    <= req_placement;
         row_ff      <= req_row;
         col_ff      <= req_column;
         len_ff      <= req_word_length;
         idx_ff      <= req_char_index;
         char_ff     <= req_character;
         large_ff    <= (req_operation == OP_WRITE_LARGE);
         rd_blank_ff <= !req_on_page;
      end
   end

   // page memory: read returns the old cell when written in the same cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= mem[unit_addr];
      end
   end

   assign we_state_ok   = state_ff inside {ST_CLEAR, ST_DRAW, ST_READ};
   assign draw_in_glyph = (p_ff < 3'(GLYPH_W)) && (y_ff < 3'(GLYPH_H));

   `TPGR_ASSERT(a_we_state, mem_we |-> we_state_ok, "page write outside clear, draw or read")
   `TPGR_STATE_NEXT(a_read_resp, ST_READ, ST_RESP, "read not followed by response")
   `TPGR_ASSERT(a_draw_range, state_ff == ST_DRAW |-> draw_in_glyph, "pixel counter out of glyph")
   `TPGR_ASSERT(a_rsp_source, $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RESP, "stray result")
   `TPGR_ASSERT(a_small_one, state_ff == ST_DRAW && !large_ff |=> state_ff == ST_IDLE, "small overrun")

endmodule
